// ----- rtl/postfix_expression_evaluator_macros.svh -----
// Assertion macros shared by the evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFX_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfx assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PFX_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfx assertion failed");

`endif

// ----- rtl/pfxeval_pkg.sv -----
`default_nettype none

package pfxeval_pkg;

   localparam int unsigned DATA_W = 64;

   // Character codes recognized by the evaluator.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   // Bit positions in the sticky error flags.
   localparam int unsigned FLAG_UNDERFLOW = 0;
   localparam int unsigned FLAG_OVERFLOW  = 1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // What the execute stage does with a request.
   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_PUSH = 3'd1,
      KIND_ADD  = 3'd2,
      KIND_SUB  = 3'd3,
      KIND_MUL  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [1:0]               status;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/postfix_expression_evaluator.sv -----
// Channel  | Direction | Handshake           | Payload
// req      | in        | req_valid/req_ready | char_byte, last_byte
// rsp      | out       | rsp_valid/rsp_ready | value, status
//
// Digits, pushes, '+' and '-' finish in execute; a request may follow every cycle while req_ready is high.
// A '*' also passes a second stage: the 64-bit product is built from three 32x32 partial
// products in that stage, and req_ready drops while the '*' is in execute.
// Reset clears the count, pending number and flags; the stack memory needs no clearing.
// A final request waits in execute (a final '*' in its second stage) while the previous result sits untaken in rsp.
`default_nettype none
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pfxeval_pkg::req_payload_type  req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pfxeval_pkg::rsp_payload_type  rsp_payload
);

   localparam int unsigned DW = pfxeval_pkg::DATA_W;
   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   // Front state, updated as each request is accepted.
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] pend_ff, pend_in;
   logic [1:0]    flags_ff, flags_in;

   // Execute stage.
   logic                    ex_vld_ff, ex_vld_in;
   pfxeval_pkg::kind_type   ex_kind_ff;
   logic [DW-1:0]           ex_val_ff;
   logic [AW-1:0]           ex_wa_ff;
   logic                    ex_we_ff;
   logic                    ex_last_ff;
   logic                    ex_empty_ff;
   pfxeval_pkg::status_type ex_status_ff;

   // Multiply completion stage.
   logic                    m2_vld_ff, m2_vld_in;
   logic                    m2_last_ff;
   logic                    m2_empty_ff;
   pfxeval_pkg::status_type m2_status_ff;
   logic [DW-1:0]           pp_ll_ff;
   logic [31:0]             pp_lh_ff;
   logic [31:0]             pp_hl_ff;

   // Top of stack lives in a register; entries below it live in the memory.
   logic [DW-1:0] top_ff;
   logic [DW-1:0] stack_mem [STACK_DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic          fwd_hit_ff;
   logic [DW-1:0] fwd_data_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   pfxeval_pkg::rsp_payload_type rsp_data_ff;

   logic                    accept;
   logic                    is_digit, is_op, last;
   logic [7:0]              digit8;
   logic [DW-1:0]           digit_ext, pend_acc, push_val;
   logic                    do_push, push_ok, op_ok, stack_full;
   logic                    unf_set, ovf_set;
   logic [CW-1:0]           cnt_upd, cnt_m1, cnt_m2;
   logic [1:0]              flags_upd;
   logic                    final_empty;
   pfxeval_pkg::status_type final_status;
   pfxeval_pkg::kind_type   kind_new;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    mem_we;
   logic                    out_blocked, ex_is_mul, ex_hold, m2_hold, ex_fire, m2_fire;
   logic                    out_load_ex, out_load_m2;
   logic [DW-1:0]           second, ex_top_new, mul_sum;
   logic [63:0]             prod_ll;
   logic [31:0]             prod_lh, prod_hl;

   // Handshake and stall control.
   assign out_blocked = rsp_valid_ff && !rsp_ready;
   assign ex_is_mul   = (ex_kind_ff == pfxeval_pkg::KIND_MUL);
   assign ex_hold     = ex_vld_ff && !ex_is_mul && ex_last_ff && out_blocked;
   assign m2_hold     = m2_vld_ff && m2_last_ff && out_blocked;
   assign ex_fire     = ex_vld_ff && !ex_hold;
   assign m2_fire     = m2_vld_ff && !m2_hold;
   assign req_ready   = !ex_hold && !m2_hold && !(ex_vld_ff && ex_is_mul);
   assign accept      = req_valid && req_ready;

   // Classify the incoming character and build the pending number.
   assign last      = req_payload.last_byte;
   assign is_digit  = (req_payload.char_byte >= pfxeval_pkg::CHAR_ZERO) &&
                      (req_payload.char_byte <= pfxeval_pkg::CHAR_NINE);
   assign is_op     = (req_payload.char_byte == pfxeval_pkg::CHAR_PLUS) ||
                      (req_payload.char_byte == pfxeval_pkg::CHAR_MINUS) ||
                      (req_payload.char_byte == pfxeval_pkg::CHAR_STAR);
   assign digit8    = req_payload.char_byte - pfxeval_pkg::CHAR_ZERO;
   assign digit_ext = {{(DW-8){1'b0}}, digit8};
   assign pend_acc  = (pend_ff << 3) + (pend_ff << 1) + digit_ext;

   // Stack bookkeeping depends only on character class, the last-byte flag and count.
   assign do_push    = is_digit ? last : !is_op;
   assign push_val   = is_digit ? pend_acc : pend_ff;
   assign stack_full = (cnt_ff == DEPTH_C);
   assign push_ok    = do_push && !stack_full;
   assign op_ok      = is_op && (cnt_ff >= CW'(2));
   assign unf_set    = is_op && !op_ok;
   assign ovf_set    = do_push && stack_full;
   assign cnt_m1     = cnt_ff - CW'(1);
   assign cnt_m2     = cnt_ff - CW'(2);

   always_comb begin
      if (push_ok) begin
         cnt_upd = cnt_ff + CW'(1);
      end else if (op_ok) begin
         cnt_upd = cnt_m1;
      end else begin
         cnt_upd = cnt_ff;
      end
   end

   assign flags_upd   = flags_ff | {ovf_set, unf_set};
   assign final_empty = (cnt_upd == '0);

   // Underflow (including an empty final stack) outranks overflow.
   always_comb begin
      if (flags_upd[pfxeval_pkg::FLAG_UNDERFLOW] || final_empty) begin
         final_status = pfxeval_pkg::STATUS_UNDERFLOW;
      end else if (flags_upd[pfxeval_pkg::FLAG_OVERFLOW]) begin
         final_status = pfxeval_pkg::STATUS_OVERFLOW;
      end else begin
         final_status = pfxeval_pkg::STATUS_OK;
      end
   end

   always_comb begin
      if (push_ok) begin
         kind_new = pfxeval_pkg::KIND_PUSH;
      end else if (op_ok) begin
         if (req_payload.char_byte == pfxeval_pkg::CHAR_PLUS) begin
            kind_new = pfxeval_pkg::KIND_ADD;
         end else if (req_payload.char_byte == pfxeval_pkg::CHAR_MINUS) begin
            kind_new = pfxeval_pkg::KIND_SUB;
         end else begin
            kind_new = pfxeval_pkg::KIND_MUL;
         end
      end else begin
         kind_new = pfxeval_pkg::KIND_NONE;
      end
   end

   // The final request of an expression restarts the front state.
   always_comb begin
      cnt_in   = cnt_ff;
      flags_in = flags_ff;
      pend_in  = pend_ff;
      if (accept) begin
         cnt_in   = last ? '0 : cnt_upd;
         flags_in = last ? '0 : flags_upd;
         pend_in  = (is_digit && !last) ? pend_acc : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         flags_ff <= '0;
         pend_ff  <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         pend_ff  <= pend_in;
      end
   end

   // Memory port usage: an operator reads the second entry, a push spills the old top.
   assign rd_en   = accept && op_ok;
   assign rd_addr = cnt_m2[AW-1:0];
   assign mem_we  = ex_fire && ex_we_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[ex_wa_ff] <= top_ff;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // A spill in the same cycle as the read of that entry is forwarded.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_hit_ff  <= mem_we && (ex_wa_ff == rd_addr);
         fwd_data_ff <= top_ff;
      end
   end

   assign second = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   // Execute stage registers.
   always_comb begin
      ex_vld_in = ex_vld_ff;
      if (accept) begin
         ex_vld_in = 1'b1;
      end else if (ex_fire) begin
         ex_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff <= 1'b0;
      end else begin
         ex_vld_ff <= ex_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_kind_ff   <= kind_new;
         ex_val_ff    <= push_val;
         ex_wa_ff     <= cnt_m1[AW-1:0];
         ex_we_ff     <= push_ok && (cnt_ff != '0);
         ex_last_ff   <= last;
         ex_empty_ff  <= final_empty;
         ex_status_ff <= final_status;
      end
   end

   // New top for push, add and subtract.
   always_comb begin
      case (ex_kind_ff)
         pfxeval_pkg::KIND_PUSH: ex_top_new = ex_val_ff;
         pfxeval_pkg::KIND_ADD:  ex_top_new = second + top_ff;
         pfxeval_pkg::KIND_SUB:  ex_top_new = second - top_ff;
         default:                ex_top_new = top_ff;
      endcase
   end

   // Partial products of the low 64 bits of second times top; the cross terms
   // only contribute their low halves.
   assign prod_ll = second[31:0] * top_ff[31:0];
   assign prod_lh = second[31:0] * top_ff[63:32];
   assign prod_hl = second[63:32] * top_ff[31:0];

   always_ff @(posedge clock) begin
      if (ex_fire && ex_is_mul) begin
         pp_ll_ff     <= prod_ll;
         pp_lh_ff     <= prod_lh;
         pp_hl_ff     <= prod_hl;
         m2_last_ff   <= ex_last_ff;
         m2_empty_ff  <= ex_empty_ff;
         m2_status_ff <= ex_status_ff;
      end
   end

   assign mul_sum = pp_ll_ff + {pp_lh_ff + pp_hl_ff, 32'd0};

   always_comb begin
      m2_vld_in = m2_vld_ff;
      if (ex_fire && ex_is_mul) begin
         m2_vld_in = 1'b1;
      end else if (m2_fire) begin
         m2_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else begin
         m2_vld_ff <= m2_vld_in;
      end
   end

   // Top-of-stack register.
   always_ff @(posedge clock) begin
      if (ex_fire && !ex_is_mul) begin
         top_ff <= ex_top_new;
      end else if (m2_fire) begin
         top_ff <= mul_sum;
      end
   end

   // Result register.
   assign out_load_ex = ex_fire && !ex_is_mul && ex_last_ff;
   assign out_load_m2 = m2_fire && m2_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load_ex || out_load_m2) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load_ex) begin
         rsp_data_ff.value  <= ex_empty_ff ? '0 : ex_top_new;
         rsp_data_ff.status <= ex_status_ff;
      end else if (out_load_m2) begin
         rsp_data_ff.value  <= m2_empty_ff ? '0 : mul_sum;
         rsp_data_ff.status <= m2_status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // A multiply in its second stage never overlaps a request in execute.
   `PFX_ASSERT_IMP(a_no_ex_m2_overlap, clock, reset, m2_vld_ff, !ex_vld_ff)
   // The entry count never passes the stack depth.
   `PFX_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= DEPTH_C)
   // A result is only loaded when the result register is free or draining.
   `PFX_ASSERT_IMP(a_out_free, clock, reset, out_load_ex || out_load_m2, !out_blocked)
   // A multiply always moves on to its second stage.
   `PFX_ASSERT_NXT(a_mul_moves, clock, reset, ex_vld_ff && ex_is_mul, m2_vld_ff)

endmodule

`default_nettype wire
